// ===== design/lfr_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lfr_pkg
// Shared types and constants of the LED frame receiver.
// ----------------------------------------------------------------------------
package lfr_pkg;

  localparam int unsigned MAX_LEDS     = 256;
  localparam int unsigned PREAMBLE_LEN = 10;

  localparam logic [7:0] POST_FIRST  = 8'd85;
  localparam logic [7:0] POST_SECOND = 8'd204;
  localparam logic [7:0] POST_THIRD  = 8'd165;

  // Event codes on the result channel.
  localparam logic [1:0] EV_PIXEL   = 2'd0;
  localparam logic [1:0] EV_COMMIT  = 2'd1;
  localparam logic [1:0] EV_REJECT  = 2'd2;
  localparam logic [1:0] EV_TIMEOUT = 2'd3;

  // Operation codes on the input channel.
  localparam logic OP_BYTE = 1'b0;
  localparam logic OP_TICK = 1'b1;

  // Register indexes of the configuration port.
  localparam logic [1:0] REG_BRIGHTNESS_MAX = 2'd0;
  localparam logic [1:0] REG_CHANNEL_FLOOR  = 2'd1;
  localparam logic [1:0] REG_TIMEOUT_TICKS  = 2'd2;
  localparam logic [1:0] REG_LED_COUNT      = 2'd3;

  localparam logic [7:0]  RST_BRIGHTNESS_MAX = 8'd120;
  localparam logic [7:0]  RST_CHANNEL_FLOOR  = 8'd30;
  localparam logic [15:0] RST_TIMEOUT_TICKS  = 16'd3000;
  localparam logic [8:0]  RST_LED_COUNT      = 9'd108;
  localparam logic [7:0]  RST_BRIGHTNESS_LVL = 8'd120;

  typedef struct packed {
    logic [7:0]  brightness_max;
    logic [7:0]  channel_floor;
    logic [15:0] timeout_ticks;
    logic [8:0]  led_count;
  } lfr_cfg_t;

  typedef struct packed {
    logic       valid;
    logic [1:0] event_kind;
    logic [7:0] led_index;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] brightness;
  } lfr_result_t;

endpackage

// ===== design/lfr_cfg_regs.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lfr_cfg_regs
// Register file behind the APB-style configuration port.
// ----------------------------------------------------------------------------
module lfr_cfg_regs
  import lfr_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output lfr_cfg_t    cfg
);

  lfr_cfg_t   cfg_r;
  logic       wr_en;
  logic [1:0] reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = paddr[3:2];
  assign cfg     = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.brightness_max <= RST_BRIGHTNESS_MAX;
      cfg_r.channel_floor  <= RST_CHANNEL_FLOOR;
      cfg_r.timeout_ticks  <= RST_TIMEOUT_TICKS;
      cfg_r.led_count      <= RST_LED_COUNT;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_BRIGHTNESS_MAX: cfg_r.brightness_max <= pwdata[7:0];
        REG_CHANNEL_FLOOR:  cfg_r.channel_floor  <= pwdata[7:0];
        REG_TIMEOUT_TICKS:  cfg_r.timeout_ticks  <= pwdata[15:0];
        REG_LED_COUNT:      cfg_r.led_count      <= pwdata[8:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_BRIGHTNESS_MAX: prdata = {24'd0, cfg_r.brightness_max};
      REG_CHANNEL_FLOOR:  prdata = {24'd0, cfg_r.channel_floor};
      REG_TIMEOUT_TICKS:  prdata = {16'd0, cfg_r.timeout_ticks};
      REG_LED_COUNT:      prdata = {23'd0, cfg_r.led_count};
      default:            prdata = 32'd0;
    endcase
  end

endmodule

// ===== design/lfr_parser.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lfr_parser
// Frame state and the single-pass decode of one staged byte or tick.
// ----------------------------------------------------------------------------
module lfr_parser
  import lfr_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  lfr_cfg_t    cfg,
  input  logic        take,
  input  logic        operation,
  input  logic [7:0]  data_byte,
  output lfr_result_t res
);

  localparam int unsigned LIM_W = 11;

  logic [3:0]  hunt_pos_r,  hunt_pos_nxt;
  logic        in_frame_r,  in_frame_nxt;
  logic [8:0]  triple_r,    triple_nxt;
  logic [1:0]  phase_r,     phase_nxt;
  logic [7:0]  first_r,     first_nxt;
  logic [7:0]  second_r,    second_nxt;
  logic [7:0]  level_r,     level_nxt;
  logic [15:0] idle_r,      idle_nxt;

  logic [16:0]      idle_inc;
  logic [LIM_W-1:0] limit;
  logic [7:0]       lift_r, lift_g, lift_b;
  logic             post_ok;

  assign idle_inc = {1'b0, idle_r} + 17'd1;
  assign limit    = ({2'b00, cfg.led_count} > LIM_W'(MAX_LEDS)) ? LIM_W'(MAX_LEDS)
                                                                : {2'b00, cfg.led_count};
  assign lift_r   = (data_byte < cfg.channel_floor) ? cfg.channel_floor : data_byte;
  assign lift_g   = (second_r < cfg.channel_floor) ? cfg.channel_floor : second_r;
  assign lift_b   = (first_r < cfg.channel_floor) ? cfg.channel_floor : first_r;
  assign post_ok  = (first_r == POST_FIRST) && (second_r == POST_SECOND) &&
                    (data_byte == POST_THIRD);

  always_comb begin
    hunt_pos_nxt = hunt_pos_r;
    in_frame_nxt = in_frame_r;
    triple_nxt   = triple_r;
    phase_nxt    = phase_r;
    first_nxt    = first_r;
    second_nxt   = second_r;
    level_nxt    = level_r;
    idle_nxt     = idle_r;
    res          = '0;

    if (!in_frame_r) begin
      if (operation == OP_TICK) begin
        if (idle_inc > {1'b0, cfg.timeout_ticks}) begin
          idle_nxt       = 16'd0;
          hunt_pos_nxt   = 4'd0;
          res.valid      = 1'b1;
          res.event_kind = EV_TIMEOUT;
        end else begin
          idle_nxt = idle_inc[15:0];
        end
      end else begin
        idle_nxt = 16'd0;
        if (data_byte == {4'd0, hunt_pos_r}) begin
          if ({1'b0, hunt_pos_r} + 5'd1 >= 5'(PREAMBLE_LEN)) begin
            in_frame_nxt = 1'b1;
            hunt_pos_nxt = 4'd0;
            triple_nxt   = 9'd0;
            phase_nxt    = 2'd0;
          end else begin
            hunt_pos_nxt = hunt_pos_r + 4'd1;
          end
        end else begin
          // A mismatching byte is not retried as the first preamble byte.
          hunt_pos_nxt = 4'd0;
        end
      end
    end else if (operation == OP_BYTE) begin
      if (phase_r == 2'd0) begin
        first_nxt = data_byte;
        phase_nxt = 2'd1;
      end else if (phase_r == 2'd1) begin
        second_nxt = data_byte;
        phase_nxt  = 2'd2;
      end else begin
        phase_nxt = 2'd0;
        res.valid = 1'b1;
        if ({2'b00, triple_r} < limit) begin
          res.event_kind = EV_PIXEL;
          res.led_index  = triple_r[7:0];
          res.red        = lift_r;
          res.green      = lift_g;
          res.blue       = lift_b;
          triple_nxt     = triple_r + 9'd1;
        end else begin
          if (post_ok) begin
            if (level_r < cfg.brightness_max) begin
              level_nxt = level_r + 8'd1;
            end else if (level_r > cfg.brightness_max) begin
              level_nxt = level_r - 8'd1;
            end
            res.event_kind = EV_COMMIT;
            res.brightness = level_nxt;
          end else begin
            res.event_kind = EV_REJECT;
          end
          in_frame_nxt = 1'b0;
          hunt_pos_nxt = 4'd0;
          idle_nxt     = 16'd0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hunt_pos_r <= 4'd0;
      in_frame_r <= 1'b0;
      triple_r   <= 9'd0;
      phase_r    <= 2'd0;
      first_r    <= 8'd0;
      second_r   <= 8'd0;
      level_r    <= RST_BRIGHTNESS_LVL;
      idle_r     <= 16'd0;
    end else if (take) begin
      hunt_pos_r <= hunt_pos_nxt;
      in_frame_r <= in_frame_nxt;
      triple_r   <= triple_nxt;
      phase_r    <= phase_nxt;
      first_r    <= first_nxt;
      second_r   <= second_nxt;
      level_r    <= level_nxt;
      idle_r     <= idle_nxt;
    end
  end

endmodule

// ===== design/led_frame_receiver_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// led_frame_receiver_unit
// Serial LED frame receiver: preamble hunt and timeout, pixel writes, postamble check.
// ----------------------------------------------------------------------------
// Usage:
// The input channel carries one item per transfer: a received serial byte
// (in_operation low) or one time tick (in_operation high). Each item lands in
// an input stage register; once the output register is free or drains, its decode
// updates the frame state and, when it causes a result, loads the output register.
// The result channel carries at most one event per input item: a pixel write, a
// frame commit, a frame reject or a hunt timeout.
// An input transfer passes the input stage register and then the output
// register before its result shows on out_valid. One item is taken per cycle
// while the output is not stalled; the combinational decode of the frame state is the only loop.
// When the receiver stalls the output register, the input stage holds one more
// item and in_stall rises only once that stage is full.
// Reset (rst_n low, synchronous) empties both stages, returns to hunting the
// preamble and loads the register defaults; configuration must be written through
// the APB-style port while the block is idle, which the block does not enforce.
// ----------------------------------------------------------------------------
module led_frame_receiver_unit
  import lfr_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_operation,
  input  logic [7:0]  in_data_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_event_kind,
  output logic [7:0]  out_led_index,
  output logic [7:0]  out_red,
  output logic [7:0]  out_green,
  output logic [7:0]  out_blue,
  output logic [7:0]  out_brightness
);

  lfr_cfg_t    cfg;
  lfr_result_t res;

  logic       stg_valid_r;
  logic       stg_op_r;
  logic [7:0] stg_byte_r;
  logic       advance;
  logic       take;
  logic       accept;

  lfr_result_t out_r;

  // The staged item moves on whenever the output register is free or drains.
  assign advance  = !out_r.valid || !out_stall;
  assign take     = stg_valid_r && advance;
  assign in_stall = stg_valid_r && !advance;
  assign accept   = in_valid && !in_stall;

  lfr_cfg_regs u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  lfr_parser u_parser (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .take      (take),
    .operation (stg_op_r),
    .data_byte (stg_byte_r),
    .res       (res)
  );

  // An empty stage fills even while the output register is stalled.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stg_valid_r <= 1'b0;
    end else if (accept) begin
      stg_valid_r <= 1'b1;
    end else if (take) begin
      stg_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      stg_op_r   <= in_operation;
      stg_byte_r <= in_data_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_r.valid <= 1'b0;
    end else if (advance) begin
      out_r.valid <= take && res.valid;
    end
    if (advance) begin
      out_r.event_kind <= res.event_kind;
      out_r.led_index  <= res.led_index;
      out_r.red        <= res.red;
      out_r.green      <= res.green;
      out_r.blue       <= res.blue;
      out_r.brightness <= res.brightness;
    end
  end

  assign out_valid      = out_r.valid;
  assign out_event_kind = out_r.event_kind;
  assign out_led_index  = out_r.led_index;
  assign out_red        = out_r.red;
  assign out_green      = out_r.green;
  assign out_blue       = out_r.blue;
  assign out_brightness = out_r.brightness;

`ifndef SYNTHESIS
  // Backpressure reaches the input only when the stage already holds an item.
  a_stall_needs_stage: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> stg_valid_r)
    else $error("in_stall raised with an empty input stage");

  // A held stage item survives a stalled cycle.
  a_stage_held: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |=> stg_valid_r)
    else $error("staged item lost while stalled");

  // A new result only appears from a staged item.
  a_result_from_stage: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(stg_valid_r))
    else $error("result appeared without a staged item");

  // Only pixel writes carry color data.
  a_color_only_pixel: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_event_kind != EV_PIXEL) |->
      (out_red == 8'd0 && out_green == 8'd0 && out_blue == 8'd0))
    else $error("non-pixel event carries color data");
`endif

endmodule

// ===== test/led_frame_receiver_unit_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// led_frame_receiver_unit_test
// Self-checking bench for the LED frame receiver.
// Serial bytes and ticks go in through a queue-fed driver. A bit-accurate
// frame decoder in the bench predicts each pixel write, commit, reject and
// timeout. A monitor compares every result transfer against the oldest
// prediction. Both sides idle at random but in one steady phase. Configuration
// changes between phases, while the receiver is quiet.
// ----------------------------------------------------------------------------
module led_frame_receiver_unit_test;
  import lfr_pkg::*;

  typedef struct packed {
    logic       op;
    logic [7:0] data;
  } serial_item_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] idx;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] bright;
  } rx_event_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [3:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic        in_operation = 1'b0;
  logic [7:0]  in_data_byte = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [1:0]  out_event_kind;
  logic [7:0]  out_led_index;
  logic [7:0]  out_red;
  logic [7:0]  out_green;
  logic [7:0]  out_blue;
  logic [7:0]  out_brightness;

  serial_item_t serial_feed[$];
  rx_event_t    awaited_events[$];
  int unsigned  mismatches = 0;
  int unsigned  fed = 0;
  bit           steady_flow = 1'b0;

  // Configuration copy of the bench.
  logic [7:0]  cfg_max = RST_BRIGHTNESS_MAX;
  logic [7:0]  cfg_min = RST_CHANNEL_FLOOR;
  logic [15:0] cfg_timeout = RST_TIMEOUT_TICKS;
  logic [8:0]  cfg_leds = RST_LED_COUNT;

  // Frame decoder state of the bench.
  int unsigned hunt_pos = 0;
  bit          framing = 1'b0;
  logic [8:0]  triple_idx = '0;
  logic [1:0]  phase = '0;
  logic [7:0]  first_byte = '0;
  logic [7:0]  second_byte = '0;
  logic [7:0]  level = RST_BRIGHTNESS_LVL;
  logic [16:0] idle_count = '0;

  led_frame_receiver_unit dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_operation  (in_operation),
    .in_data_byte  (in_data_byte),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_event_kind(out_event_kind),
    .out_led_index (out_led_index),
    .out_red       (out_red),
    .out_green     (out_green),
    .out_blue      (out_blue),
    .out_brightness(out_brightness)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic logic [7:0] floor_channel(input logic [7:0] v);
    return (v < cfg_min) ? cfg_min : v;
  endfunction

  function automatic void decode_item(input logic op, input logic [7:0] b);
    rx_event_t   ev;
    int unsigned limit;
    ev = '0;
    if (!framing) begin
      if (op == OP_TICK) begin
        if (idle_count + 17'd1 > {1'b0, cfg_timeout}) begin
          idle_count = '0;
          hunt_pos = 0;
          ev.kind = EV_TIMEOUT;
          awaited_events.push_back(ev);
        end else begin
          idle_count = idle_count + 17'd1;
        end
        return;
      end
      idle_count = '0;
      // A mismatching byte is not retried as the first preamble byte.
      if (int'(b) == hunt_pos) begin
        if (hunt_pos + 1 >= PREAMBLE_LEN) begin
          framing = 1'b1;
          hunt_pos = 0;
          triple_idx = '0;
          phase = '0;
        end else begin
          hunt_pos = hunt_pos + 1;
        end
      end else begin
        hunt_pos = 0;
      end
      return;
    end
    if (op == OP_TICK) return;
    if (phase == 2'd0) begin
      first_byte = b;
      phase = 2'd1;
      return;
    end
    if (phase == 2'd1) begin
      second_byte = b;
      phase = 2'd2;
      return;
    end
    phase = 2'd0;
    limit = (cfg_leds > MAX_LEDS) ? MAX_LEDS : cfg_leds;
    if (triple_idx < limit) begin
      ev.kind = EV_PIXEL;
      ev.idx = triple_idx[7:0];
      ev.red = floor_channel(b);
      ev.green = floor_channel(second_byte);
      ev.blue = floor_channel(first_byte);
      triple_idx = triple_idx + 9'd1;
      awaited_events.push_back(ev);
      return;
    end
    if (first_byte == POST_FIRST && second_byte == POST_SECOND && b == POST_THIRD) begin
      if (level < cfg_max) level = level + 8'd1;
      else if (level > cfg_max) level = level - 8'd1;
      ev.kind = EV_COMMIT;
      ev.bright = level;
    end else begin
      ev.kind = EV_REJECT;
    end
    awaited_events.push_back(ev);
    framing = 1'b0;
    hunt_pos = 0;
    idle_count = '0;
    phase = '0;
  endfunction

  // Driver: predicts on each accepted transfer, then presents the next item.
  always @(posedge clk) begin
    serial_item_t item;
    if (rst_n) begin
      if (in_valid && !in_stall) decode_item(in_operation, in_data_byte);
      if (!in_valid || !in_stall) begin
        if (serial_feed.size() != 0 && (steady_flow || $urandom_range(0, 99) >= 37)) begin
          item = serial_feed.pop_front();
          in_valid <= 1'b1;
          in_operation <= item.op;
          in_data_byte <= item.data;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  task automatic check_field(input string name, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endtask

  // Monitor.
  always @(posedge clk) begin
    rx_event_t ev;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (awaited_events.size() == 0) begin
          $error("result transfer with nothing expected, event_kind %0d", out_event_kind);
          mismatches++;
        end else begin
          ev = awaited_events.pop_front();
          check_field("event_kind", ev.kind, out_event_kind);
          check_field("led_index", ev.idx, out_led_index);
          check_field("red", ev.red, out_red);
          check_field("green", ev.green, out_green);
          check_field("blue", ev.blue, out_blue);
          check_field("brightness", ev.bright, out_brightness);
        end
      end
      out_stall <= steady_flow ? 1'b0 : ($urandom_range(0, 99) < 37);
    end
  end

  task automatic cfg_write(input logic [1:0] idx, input logic [31:0] value);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      REG_BRIGHTNESS_MAX: cfg_max = value[7:0];
      REG_CHANNEL_FLOOR:  cfg_min = value[7:0];
      REG_TIMEOUT_TICKS:  cfg_timeout = value[15:0];
      REG_LED_COUNT:      cfg_leds = value[8:0];
      default: ;
    endcase
  endtask

  task automatic apply_settings(input logic [7:0] bmax, input logic [7:0] bmin,
                                input logic [15:0] ticks, input logic [8:0] leds);
    cfg_write(REG_BRIGHTNESS_MAX, {24'd0, bmax});
    cfg_write(REG_CHANNEL_FLOOR, {24'd0, bmin});
    cfg_write(REG_TIMEOUT_TICKS, {16'd0, ticks});
    cfg_write(REG_LED_COUNT, {23'd0, leds});
  endtask

  // Waits until every item is in and every result is out, then lets the
  // pipeline finish items that produce no result.
  task automatic wait_quiet();
    int unsigned waited;
    waited = 0;
    while ((serial_feed.size() != 0 || in_valid || awaited_events.size() != 0)
           && waited < 50000) begin
      @(negedge clk);
      waited++;
    end
    if (awaited_events.size() != 0) begin
      $error("%0d expected results never arrived", awaited_events.size());
      mismatches++;
      awaited_events.delete();
    end
    repeat (8) @(posedge clk);
  endtask

  task automatic add_item(input logic op, input logic [7:0] b);
    serial_feed.push_back(serial_item_t'({op, b}));
    fed++;
  endtask

  task automatic add_preamble();
    for (int i = 0; i < PREAMBLE_LEN; i++) add_item(OP_BYTE, 8'(i));
  endtask

  task automatic add_frame(input int unsigned triples, input bit clean_tail);
    logic [7:0] tail[3];
    int unsigned spoil;
    add_preamble();
    for (int i = 0; i < 3 * triples; i++) add_item(OP_BYTE, 8'($urandom_range(0, 255)));
    tail[0] = POST_FIRST;
    tail[1] = POST_SECOND;
    tail[2] = POST_THIRD;
    if (!clean_tail) begin
      spoil = $urandom_range(0, 2);
      tail[spoil] = 8'($urandom_range(0, 255));
    end
    for (int i = 0; i < 3; i++) add_item(OP_BYTE, tail[i]);
  endtask

  task automatic add_segment();
    int unsigned r;
    int unsigned n;
    r = $urandom_range(0, 99);
    if (r < 65) begin
      add_frame((cfg_leds > MAX_LEDS) ? MAX_LEDS : cfg_leds, $urandom_range(0, 99) < 80);
    end else if (r < 75) begin
      // Preamble that breaks off part way.
      n = $urandom_range(0, PREAMBLE_LEN - 1);
      for (int i = 0; i < n; i++) add_item(OP_BYTE, 8'(i));
      add_item(OP_BYTE, 8'($urandom_range(0, 255)));
    end else if (r < 87) begin
      n = (cfg_timeout > 20) ? $urandom_range(1, 20) : $urandom_range(1, cfg_timeout + 3);
      for (int i = 0; i < n; i++) add_item(OP_TICK, 8'($urandom_range(0, 255)));
    end else begin
      n = $urandom_range(1, 6);
      for (int i = 0; i < n; i++) add_item(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
    end
  endtask

  initial begin
    int unsigned goal;
    logic [15:0] ticks;
    logic [8:0]  leds;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // Reset settings: a tick far below the limit and a broken preamble.
    add_item(OP_TICK, 8'h00);
    add_item(OP_BYTE, 8'h00);
    add_item(OP_BYTE, 8'h01);
    add_item(OP_BYTE, 8'h05);
    add_item(OP_BYTE, 8'h00);
    wait_quiet();

    // A zero limit times out on the first tick; one pixel frame, then commit.
    apply_settings(8'd255, 8'd0, 16'd0, 9'd1);
    add_item(OP_TICK, 8'hFF);
    add_preamble();
    add_item(OP_BYTE, 8'h00);
    add_item(OP_BYTE, 8'hAA);
    add_item(OP_TICK, 8'h55);
    add_item(OP_BYTE, 8'hFF);
    add_item(OP_BYTE, POST_FIRST);
    add_item(OP_BYTE, POST_SECOND);
    add_item(OP_BYTE, POST_THIRD);
    wait_quiet();

    // Frame of the postamble alone: first spoiled, then clean.
    apply_settings(8'd0, 8'd255, 16'd65535, 9'd0);
    add_preamble();
    add_item(OP_BYTE, POST_FIRST);
    add_item(OP_BYTE, POST_SECOND);
    add_item(OP_BYTE, 8'd164);
    add_item(OP_TICK, 8'h00);
    add_frame(0, 1'b1);
    wait_quiet();

    // Led count lowered part way through a frame: the next triple closes it.
    cfg_write(REG_LED_COUNT, 32'd4);
    add_preamble();
    for (int i = 0; i < 6; i++) add_item(OP_BYTE, 8'(250 + i));
    wait_quiet();
    cfg_write(REG_LED_COUNT, 32'd1);
    add_item(OP_BYTE, POST_FIRST);
    add_item(OP_BYTE, POST_SECOND);
    add_item(OP_BYTE, POST_THIRD);
    wait_quiet();

    for (int p = 0; p < 8; p++) begin
      ticks = ($urandom_range(0, 3) == 0) ? 16'($urandom_range(11, 65535))
                                         : 16'($urandom_range(0, 10));
      leds = ($urandom_range(0, 4) == 0) ? 9'($urandom_range(9, 20))
                                         : 9'($urandom_range(0, 8));
      case (p)
        0: apply_settings(8'd255, 8'd0, 16'd0, leds);
        1: apply_settings(8'd0, 8'd255, 16'd65535, leds);
        2: apply_settings(8'($urandom_range(0, 255)), 8'($urandom_range(0, 80)), ticks,
                          9'($urandom_range(257, 511)));
        default: apply_settings(8'($urandom_range(0, 255)), 8'($urandom_range(0, 120)),
                                ticks, leds);
      endcase
      steady_flow <= (p == 4);
      fed = 0;
      if (p == 2) begin
        // One full-size frame; the led index runs through all of its values.
        add_frame(MAX_LEDS, 1'b1);
        goal = fed;
      end else begin
        goal = 140;
      end
      while (fed < goal) add_segment();
      wait_quiet();
    end

    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
